// File: design/separable_box_blur_3x3_assert.svh
// Assertion macros used by the checker file of the separable box blur.
// Plain text only; no dependencies.
`ifndef SEPARABLE_BOX_BLUR_3X3_ASSERT_SVH
`define SEPARABLE_BOX_BLUR_3X3_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define SBB_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SBB_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sbb_pkg.sv
// Shared types, constants and the divide-by-3 function of the box blur.
// No dependencies.
package sbb_pkg;

    localparam int PIX_W         = 16;
    localparam int HVAL_W        = 15;
    localparam int CNT_W         = 12;
    localparam int CFG_W         = 13;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int MAX_WIDTH_DEF = 4096;

    localparam logic [CFG_W-1:0]  MIN_SIZE         = 13'd3;
    localparam logic [CFG_W-1:0]  MAX_HEIGHT       = 13'd4096;
    localparam logic [CFG_W-1:0]  LINE_WIDTH_RST   = 13'd4096;
    localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RST = 13'd4096;
    localparam logic [HVAL_W-1:0] BLUR_MAX         = 15'd21845;

    // Register select: bit 2 of the byte address.
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // ceil(2^17 / 3): exact floor(x / 3) for any 16-bit x after a shift by 17.
    localparam logic [16:0] DIV3_RECIP = 17'd43691;

    typedef struct packed {
        logic [CFG_W-1:0] line_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              in_range;
        logic              emit;
        logic              row_end;
        logic              frame_end;
        logic [HVAL_W-1:0] hval;
    } stage_t;

    function automatic logic [HVAL_W-1:0] div3(input logic [PIX_W-1:0] x);
        logic [32:0] prod;
        prod = {17'b0, x} * {16'b0, DIV3_RECIP};
        return prod[31:17];
    endfunction

endpackage

// File: design/sbb_regs.sv
// Configuration registers of the box blur behind an APB-style port.
// Depends on sbb_pkg.
module sbb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbb_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbb_pkg::DATA_W-1:0]   pwdata,
    output logic [sbb_pkg::DATA_W-1:0]   prdata,
    output sbb_pkg::cfg_t                cfg
);
    import sbb_pkg::*;

    logic [CFG_W-1:0] line_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             wr_en;
    logic             reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default:          line_width_reg   <= line_width_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LINE_WIDTH:   prdata = {{(DATA_W-CFG_W){1'b0}}, line_width_reg};
            REG_FRAME_HEIGHT: prdata = {{(DATA_W-CFG_W){1'b0}}, frame_height_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.line_width   = line_width_reg;
    assign cfg.frame_height = frame_height_reg;

endmodule

// File: design/sbb_line_ram.sv
// One line store: simple dual-port RAM, one write and one registered read per cycle.
// Depends on sbb_pkg for the entry width.
module sbb_line_ram #(
    parameter int DEPTH = sbb_pkg::MAX_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [sbb_pkg::HVAL_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [sbb_pkg::HVAL_W-1:0] rd_data
);
    import sbb_pkg::*;

    logic [HVAL_W-1:0] mem [DEPTH];
    logic [HVAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/sbb_hpass.sv
// Input stage of the box blur: raster counters, horizontal 3-tap sum and divide,
// and the stage register that feeds the vertical pass. Depends on sbb_pkg.
module sbb_hpass #(
    parameter int MAX_WIDTH = sbb_pkg::MAX_WIDTH_DEF,
    localparam int AW       = $clog2(MAX_WIDTH)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sbb_pkg::cfg_t             cfg,
    input  logic                      accept,
    input  logic [sbb_pkg::PIX_W-1:0] pixel,
    input  logic                      b_go,
    output logic [AW-1:0]             rd_addr,
    output logic [AW-1:0]             stage_addr,
    output sbb_pkg::stage_t           stage
);
    import sbb_pkg::*;

    localparam logic [16:0] MaxW = 17'(MAX_WIDTH);

    logic [PIX_W-1:0] prev1_reg;
    logic [PIX_W-1:0] prev2_reg;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    stage_t           stage_reg;
    stage_t           stage_next;
    logic [AW-1:0]    addr_reg;

    logic [16:0]      lw_ext;
    logic [16:0]      w_eff;
    logic [16:0]      col_ext;
    logic [CFG_W-1:0] h_eff;
    logic             last_col;
    logic             last_row;
    logic             in_range;
    logic [PIX_W-1:0] hsum;

    // Clamp the register values into their legal ranges.
    always_comb begin
        lw_ext = 17'(cfg.line_width);
        if (lw_ext < 17'(MIN_SIZE)) begin
            w_eff = 17'(MIN_SIZE);
        end else if (lw_ext > MaxW) begin
            w_eff = MaxW;
        end else begin
            w_eff = lw_ext;
        end
        if (cfg.frame_height < MIN_SIZE) begin
            h_eff = MIN_SIZE;
        end else if (cfg.frame_height > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end else begin
            h_eff = cfg.frame_height;
        end
    end

    assign col_ext  = 17'(col_reg);
    assign last_col = col_ext >= (w_eff - 17'd1);
    assign last_row = {1'b0, row_reg} >= (h_eff - 13'd1);
    assign in_range = (col_reg >= 12'd2) && (col_ext < MaxW);
    assign hsum     = prev2_reg + prev1_reg + pixel;
    assign rd_addr  = col_ext[AW-1:0];

    always_comb begin
        col_next = col_reg + 12'd1;
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + 12'd1;
        end
    end

    always_comb begin
        stage_next           = stage_reg;
        if (accept) begin
            stage_next.valid     = 1'b1;
            stage_next.in_range  = in_range;
            stage_next.emit      = in_range && (row_reg >= 12'd2);
            stage_next.row_end   = last_col;
            stage_next.frame_end = last_col && last_row;
            stage_next.hval      = div3(hsum);
        end else if (b_go) begin
            stage_next.valid     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev1_reg       <= '0;
            prev2_reg       <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            stage_reg.valid <= 1'b0;
        end else begin
            stage_reg.valid <= stage_next.valid;
            if (accept) begin
                prev1_reg <= pixel;
                prev2_reg <= prev1_reg;
                col_reg   <= col_next;
                row_reg   <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg.in_range  <= stage_next.in_range;
        stage_reg.emit      <= stage_next.emit;
        stage_reg.row_end   <= stage_next.row_end;
        stage_reg.frame_end <= stage_next.frame_end;
        stage_reg.hval      <= stage_next.hval;
        if (accept) begin
            addr_reg <= rd_addr;
        end
    end

    assign stage      = stage_reg;
    assign stage_addr = addr_reg;

endmodule

// File: design/sbb_vpass.sv
// Vertical pass of the box blur: 3-tap column sum, divide by 3, result register
// and the flow control of the stage ahead of it. Depends on sbb_pkg.
module sbb_vpass (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sbb_pkg::stage_t            stage,
    input  logic [sbb_pkg::HVAL_W-1:0] older,
    input  logic [sbb_pkg::HVAL_W-1:0] newer,
    input  logic                       m_ready,
    output logic                       b_go,
    output logic                       m_valid,
    output logic [sbb_pkg::HVAL_W-1:0] m_blurred,
    output logic                       m_row_end,
    output logic                       m_frame_end
);
    import sbb_pkg::*;

    logic              m_valid_reg;
    logic [HVAL_W-1:0] blurred_reg;
    logic              row_end_reg;
    logic              frame_end_reg;
    logic [PIX_W-1:0]  vsum;
    logic              out_free;
    logic              load;

    // At most 3 * 21845, so the sum never wraps.
    assign vsum     = PIX_W'(older) + PIX_W'(newer) + PIX_W'(stage.hval);
    assign out_free = !m_valid_reg || m_ready;
    assign b_go     = stage.valid && (!stage.emit || out_free);
    assign load     = b_go && stage.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            blurred_reg   <= div3(vsum);
            row_end_reg   <= stage.row_end;
            frame_end_reg <= stage.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_blurred   = blurred_reg;
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

// File: design/separable_box_blur_3x3.sv
// Separable 3x3 box blur over a raster stream of 16-bit pixels. One pixel is
// taken per clock with no bubbles while the output does not stall: each line
// store is read once and written at most once per pixel, on separate ports, and
// that single read/write pair per item sets the rate. A result goes through the
// stage register to the m_ register and waits while the next pixel is taken.
// Results come only for columns and rows from 2 on, so the output frame is two
// smaller each way; m_row_end and m_frame_end mark the last pixel of a row and
// of the frame. Program line_width and frame_height only while the block is idle;
// out-of-range values are clamped to [3, MAX_WIDTH] and [3, 4096]. Line stores
// need no clearing after reset: every entry is written before its value is used.
// Depends on sbb_pkg and the sbb_ submodules.
module separable_box_blur_3x3 #(
    parameter int MAX_WIDTH = sbb_pkg::MAX_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sbb_pkg::ADDR_W-1:0] paddr,
    input  logic [sbb_pkg::DATA_W-1:0] pwdata,
    output logic [sbb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // pixel input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sbb_pkg::PIX_W-1:0]  s_pixel,
    // blurred output
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [sbb_pkg::HVAL_W-1:0] m_blurred,
    output logic                       m_row_end,
    output logic                       m_frame_end
);
    import sbb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    cfg_t              cfg;
    stage_t            stage;
    logic              accept;
    logic              b_go;
    logic              ram_wr;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     stage_addr;
    logic [HVAL_W-1:0] older_rd;
    logic [HVAL_W-1:0] newer_rd;

    // Register writes complete in the access phase; no wait states.
    assign pready = 1'b1;

    sbb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Take a new transaction whenever the stage register is empty or drains
    // this cycle; only a full, waiting m_ register stalls it, on a result.
    assign s_ready = !stage.valid || b_go;
    assign accept  = s_valid && s_ready;

    sbb_hpass #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_hpass (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .pixel      (s_pixel),
        .b_go       (b_go),
        .rd_addr    (rd_addr),
        .stage_addr (stage_addr),
        .stage      (stage)
    );

    // Shift the column down by one row as the stage drains: the older store
    // takes what the newer one held, the newer store takes this row's value.
    // Read and write addresses of neighboring transactions always differ.
    assign ram_wr = b_go && stage.in_range;

    sbb_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (stage_addr),
        .wr_data (newer_rd),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (older_rd)
    );

    sbb_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (stage_addr),
        .wr_data (stage.hval),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (newer_rd)
    );

    // Finish the vertical average and hold it until the transaction is taken.
    sbb_vpass u_vpass (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage       (stage),
        .older       (older_rd),
        .newer       (newer_rd),
        .m_ready     (m_ready),
        .b_go        (b_go),
        .m_valid     (m_valid),
        .m_blurred   (m_blurred),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

endmodule

// File: design/sbb_checker.sv
// Port-level checks on the blur's result channel, bound to the top level.
// Depends on sbb_pkg and separable_box_blur_3x3_assert.svh.
`include "separable_box_blur_3x3_assert.svh"

module sbb_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [sbb_pkg::HVAL_W-1:0] m_blurred,
    input logic                       m_row_end,
    input logic                       m_frame_end
);
    import sbb_pkg::*;

    `SBB_ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped")
    `SBB_ASSERT_NEXT(a_data_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_blurred) && $stable(m_row_end) && $stable(m_frame_end), "payload changed")
    `SBB_ASSERT_IMPL(a_frame_row, aclk, aresetn, m_valid && m_frame_end, m_row_end, "frame end off row end")
    `SBB_ASSERT_IMPL(a_range, aclk, aresetn, m_valid, m_blurred <= BLUR_MAX, "blurred out of range")

endmodule

bind separable_box_blur_3x3 sbb_checker u_sbb_checker (.*);

// File: sim/separable_box_blur_3x3_test.sv
// Self-checking testbench for separable_box_blur_3x3: pixel frames in, blurred pixels out.
// A cycle-free predictor of the 3x3 blur is scored against every output transaction.
// Depends on sbb_pkg and the separable_box_blur_3x3 RTL.
`timescale 1ns / 100ps

module separable_box_blur_3x3_test;

    // Receiver hold-off used by the backpressure test, in clock cycles.
    localparam int OUT_HOLD_CYCLES = 600;
    // Bound on how long a drain waits for the predicted outputs to arrive.
    localparam int DRAIN_LIMIT     = 5000;
    // Cycles a pixel needs to clear the pipeline even when it makes no output.
    localparam int PIPE_FLUSH      = 4;
    localparam int RANDOM_PIXELS   = 420;

    typedef struct packed {
        logic [sbb_pkg::HVAL_W-1:0] blurred;
        logic                       row_end;
        logic                       frame_end;
    } blur_out_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [sbb_pkg::ADDR_W-1:0] paddr;
    logic [sbb_pkg::DATA_W-1:0] pwdata;
    logic [sbb_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic [sbb_pkg::PIX_W-1:0]  s_pixel;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [sbb_pkg::HVAL_W-1:0] m_blurred;
    logic                       m_row_end;
    logic                       m_frame_end;

    separable_box_blur_3x3 DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_blurred   (m_blurred),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the block's registers, counters,
    // pixel history and the two line stores of horizontal averages.
    // ------------------------------------------------------------------
    logic [sbb_pkg::CFG_W-1:0]  cfg_width  = sbb_pkg::LINE_WIDTH_RST;
    logic [sbb_pkg::CFG_W-1:0]  cfg_height = sbb_pkg::FRAME_HEIGHT_RST;
    logic [sbb_pkg::PIX_W-1:0]  prev_px1   = '0;
    logic [sbb_pkg::PIX_W-1:0]  prev_px2   = '0;
    logic [sbb_pkg::HVAL_W-1:0] line_older [0:sbb_pkg::MAX_WIDTH_DEF-1];
    logic [sbb_pkg::HVAL_W-1:0] line_newer [0:sbb_pkg::MAX_WIDTH_DEF-1];
    int                         col_pos    = 0;
    int                         row_pos    = 0;

    blur_out_t predicted_blur[$];

    int   fault_count   = 0;
    int   pixels_sent   = 0;
    int   send_idle_pct = 20;
    int   recv_idle_pct = 20;
    int   recv_wait     = 0;
    logic hold_output;
    event hold_kick;

    // Free-running clock, 10 ns period.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Saturate a programmed size to the range the block really uses.
    function automatic int fit_size(input int v);
        if (v < 3)
            return 3;
        if (v > sbb_pkg::MAX_WIDTH_DEF)
            return sbb_pkg::MAX_WIDTH_DEF;
        return v;
    endfunction

    // Idle length for one side: mostly none, some short, a few long.
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // Pixel source biased toward the extremes so the 16-bit sum wraps often.
    function automatic logic [sbb_pkg::PIX_W-1:0] pick_pixel();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'hFFF0 | r[3:0];
            default: return r[15:0];
        endcase
    endfunction

    // Advance the blur predictor by one accepted pixel; queue the blurred
    // pixel it produces, if any.
    task automatic advance_blur(input logic [sbb_pkg::PIX_W-1:0] px);
        int                         w;
        int                         h;
        int                         vsum;
        logic                       last_col;
        logic                       last_row;
        logic [sbb_pkg::PIX_W-1:0]  hsum;
        logic [sbb_pkg::HVAL_W-1:0] hval;
        logic [sbb_pkg::HVAL_W-1:0] older;
        logic [sbb_pkg::HVAL_W-1:0] newer;
        blur_out_t                  res;
        w        = fit_size(cfg_width);
        h        = fit_size(cfg_height);
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        if (col_pos >= 2) begin
            // Horizontal pass: the sum wraps at 16 bits before the divide.
            hsum  = prev_px2 + prev_px1 + px;
            hval  = hsum / 3;
            older = line_older[col_pos];
            newer = line_newer[col_pos];
            if (row_pos >= 2) begin
                vsum          = older + newer + hval;
                res.blurred   = vsum / 3;
                res.row_end   = last_col;
                res.frame_end = last_col && last_row;
                predicted_blur.push_back(res);
            end
            // Shift the column's history down one row.
            line_older[col_pos] = newer;
            line_newer[col_pos] = hval;
        end
        prev_px2 = prev_px1;
        prev_px1 = px;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // Score one output transaction against the oldest prediction.
    task automatic check_blur(input logic [sbb_pkg::HVAL_W-1:0] got, input logic got_row,
                              input logic got_frame);
        blur_out_t want;
        if (predicted_blur.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("%0t: unexpected output blurred=%0d row_end=%b frame_end=%b",
                         $time, got, got_row, got_frame);
        end else begin
            want = predicted_blur.pop_front();
            if (want.blurred !== got || want.row_end !== got_row
                    || want.frame_end !== got_frame) begin
                fault_count++;
                if (fault_count <= 10)
                    $display({"%0t: mismatch: expected blurred=%0d row_end=%b frame_end=%b,",
                              " got blurred=%0d row_end=%b frame_end=%b"},
                             $time, want.blurred, want.row_end, want.frame_end,
                             got, got_row, got_frame);
            end
        end
    endtask

    // Output side: score each accepted transaction, then pick the next
    // m_ready. A long hold-off overrides the random gaps.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_blur(m_blurred, m_row_end, m_frame_end);
        if (hold_output) begin
            m_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            m_ready   <= 1'b0;
            recv_wait <= recv_wait - 1;
        end else begin
            m_ready   <= 1'b1;
            recv_wait <= pick_gap(recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and
    // the block has to fill up and drop s_ready.
    initial begin
        hold_output <= 1'b0;
        forever begin
            @(hold_kick);
            @(posedge aclk);
            hold_output <= 1'b1;
            repeat (OUT_HOLD_CYCLES) @(posedge aclk);
            hold_output <= 1'b0;
        end
    end

    // Offer one pixel after a random gap; hold it until accepted, then
    // advance the predictor.
    task automatic send_pixel(input logic [sbb_pkg::PIX_W-1:0] px);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        advance_blur(px);
        pixels_sent++;
    endtask

    // Drop s_valid, let every predicted output arrive, then let the last
    // pixels that make no output clear the pipeline.
    task automatic wait_idle();
        int spins;
        spins = 0;
        s_valid <= 1'b0;
        while (predicted_blur.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
        repeat (PIPE_FLUSH) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access until pready. Junk in the upper
    // data bits must be ignored by the 13-bit registers.
    task automatic write_reg(input logic sel, input logic [sbb_pkg::CFG_W-1:0] value);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {junk[31:sbb_pkg::CFG_W], value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == sbb_pkg::REG_LINE_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        // Keep the bus idle after the write so back-to-back writes never
        // retarget psel within one step.
        @(posedge aclk);
    endtask

    // Send random pixels until the predicted counters wrap to the frame
    // start. At pixel number break_at, if still mid-frame, shrink one size.
    task automatic run_frame(input int break_at);
        int sent;
        int v;
        sent = 0;
        do begin
            send_pixel(pick_pixel());
            sent++;
            if (sent == break_at && (col_pos != 0 || row_pos != 0)) begin
                wait_idle();
                // Only shrink: a wider row mid-frame would read unwritten line store.
                if ($urandom_range(1)) begin
                    v = $urandom_range(fit_size(cfg_width), 0);
                    write_reg(sbb_pkg::REG_LINE_WIDTH, v[sbb_pkg::CFG_W-1:0]);
                end else begin
                    v = $urandom_range(fit_size(cfg_height), 0);
                    write_reg(sbb_pkg::REG_FRAME_HEIGHT, v[sbb_pkg::CFG_W-1:0]);
                end
            end
        end while (col_pos != 0 || row_pos != 0);
    endtask

    // Start at the reset sizes, then shrink both mid-row; all-ones pixels
    // make the horizontal sum wrap.
    task automatic test_reset_then_resize();
        int k;
        k = 0;
        repeat (5) begin
            send_pixel((k % 4 == 3) ? 16'h0000 : 16'hFFFF);
            k++;
        end
        wait_idle();
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd5);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'd3);
        // Column 5 is already past the new last column: the next pixel ends row 0.
        do begin
            send_pixel((k % 3 == 0) ? 16'h8000 : 16'hFFFF);
            k++;
        end while (col_pos != 0 || row_pos != 0);
    endtask

    // Sizes below the minimum clamp to a 3x3 frame; rows of FFFF,0,0 give
    // the largest possible output on a pixel that ends row and frame.
    task automatic test_peak_output();
        wait_idle();
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd2);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'd1);
        repeat (3) begin
            send_pixel(16'hFFFF);
            send_pixel(16'h0000);
            send_pixel(16'h0000);
        end
    endtask

    // Oversized registers saturate; then shrink width mid-row and height past the
    // current row, then width past the current column, which ends the frame at once.
    task automatic test_mid_frame_shrink();
        wait_idle();
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'h1FFF);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        repeat (5) send_pixel(pick_pixel());
        wait_idle();
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd8);
        while (row_pos != 5 || col_pos != 3)
            send_pixel(pick_pixel());
        wait_idle();
        // Row 5 is past the new last row: this row closes the frame.
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'd4);
        repeat (2) send_pixel(pick_pixel());
        wait_idle();
        // Column 5 is past the new last column: the next pixel ends the frame.
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd4);
        run_frame(0);
    endtask

    // Widest row with the shortest frame, cut short by a width shrink, then
    // narrowest row with the tallest frame, cut short by a height shrink.
    // Keep idling light.
    task automatic test_size_extremes();
        send_idle_pct = 2;
        recv_idle_pct = 2;
        wait_idle();
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd4096);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'd0);
        repeat (40) send_pixel(pick_pixel());
        wait_idle();
        // Column 40 is past the last column of a 3-pixel row: the next pixel ends row 0.
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd3);
        run_frame(0);
        wait_idle();
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd1);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'd4096);
        repeat (60) send_pixel(pick_pixel());
        wait_idle();
        // Row 20 is past the last row of a 3-row frame: this row closes the frame.
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'd3);
        run_frame(0);
    endtask

    // Stall the output for a long stretch while pixels keep coming, so the
    // block fills and pushes back on its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_idle();
        write_reg(sbb_pkg::REG_LINE_WIDTH, 13'd12);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 13'd8);
        -> hold_kick;
        run_frame(0);
    endtask

    // Whole frames of random sizes and content under varying idling; about
    // one frame in four is broken by a mid-frame shrink.
    task automatic test_random_frames();
        int target;
        int w;
        int h;
        int brk;
        target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target) begin
            wait_idle();
            case ($urandom_range(3))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 15;
                default: send_idle_pct = 40;
            endcase
            case ($urandom_range(3))
                0:       recv_idle_pct = 0;
                1:       recv_idle_pct = 15;
                default: recv_idle_pct = 50;
            endcase
            case ($urandom_range(9))
                0:       w = $urandom_range(2, 0);
                1:       w = $urandom_range(64, 17);
                default: w = $urandom_range(16, 3);
            endcase
            h = ($urandom_range(7) == 0) ? $urandom_range(2, 0) : $urandom_range(6, 3);
            write_reg(sbb_pkg::REG_LINE_WIDTH, w[sbb_pkg::CFG_W-1:0]);
            write_reg(sbb_pkg::REG_FRAME_HEIGHT, h[sbb_pkg::CFG_W-1:0]);
            brk = ($urandom_range(3) == 0) ? $urandom_range(3 * fit_size(w), 1) : 0;
            run_frame(brk);
        end
    endtask

    // Main sequence: reset once, run each test in turn, drain, report.
    initial begin
        aresetn <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_valid <= 1'b0;
        s_pixel <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_then_resize();
        test_peak_output();
        test_mid_frame_shrink();
        test_size_extremes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        if (predicted_blur.size() != 0) begin
            $display("%0t: %0d predicted outputs never arrived", $time, predicted_blur.size());
            fault_count += predicted_blur.size();
        end
        if (fault_count == 0)
            $display("[separable_box_blur_3x3] OK");
        else
            $display("[separable_box_blur_3x3] ERROR");
        $finish;
    end

    // Watchdog: 20 ms is many times the slowest legal run.
    initial begin
        #20_000_000;
        $display("[separable_box_blur_3x3] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/sbb_pkg.sv
design/sbb_regs.sv
design/sbb_line_ram.sv
design/sbb_hpass.sv
design/sbb_vpass.sv
design/separable_box_blur_3x3.sv
design/sbb_checker.sv
sim/separable_box_blur_3x3_test.sv
